>>> rtl/rvm_pkg.sv
// ----------------------------------------------------------------------------
// rvm_pkg: shared types and constants of the repetition velocity meter
// Configuration indexes and reset values, divider widths and the request and
// response bundles that pass between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package rvm_pkg;

    // sample limits
    localparam int unsigned RANGE_W      = 8;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned ELAPSED_W    = TIME_W - 1;
    localparam int unsigned MAX_RANGE_CM = 200;
    localparam logic [RANGE_W-1:0]   MAX_RANGE   = RANGE_W'(MAX_RANGE_CM);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // configuration port
    localparam int unsigned CFG_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LEVEL  = 2'd0,
        CFG_HIGH_LEVEL = 2'd1,
        CFG_ERR_LIMIT  = 2'd2,
        CFG_FULL_SPEED = 2'd3
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] LOW_LEVEL_RST  = 8'd35;
    localparam logic [CFG_W-1:0] HIGH_LEVEL_RST = 8'd45;
    localparam logic [CFG_W-1:0] ERR_LIMIT_RST  = 8'd150;
    localparam logic [CFG_W-1:0] FULL_SPEED_RST = 8'd50;

    // arithmetic constants
    localparam int unsigned SPEED_W    = 8;
    localparam int unsigned PROD_W     = 16;
    localparam logic [9:0]  SCALE_MS   = 10'd1000;
    localparam logic [7:0]  FULL_ANGLE = 8'd180;

    // shared divider: 255 cm * 1000 fits in 18 bits
    localparam int unsigned DVD_W = 18;
    localparam int unsigned CNT_W = $clog2(DVD_W + 1);
    localparam logic [CNT_W-1:0] VEL_ITERS = CNT_W'(DVD_W);
    localparam logic [CNT_W-1:0] ACC_ITERS = CNT_W'(SPEED_W);
    localparam logic [CNT_W-1:0] ANG_ITERS = CNT_W'(PROD_W);

    typedef struct packed {
        logic                 start;
        logic [CNT_W-1:0]     iters;
        logic [DVD_W-1:0]     dividend;
        logic [ELAPSED_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/rvm_div.sv
// ----------------------------------------------------------------------------
// rvm_div: shared restoring divider
// One quotient bit per cycle. The dividend arrives left-aligned, so a request
// for n iterations yields an n-bit quotient in the low bits.
// ----------------------------------------------------------------------------
module rvm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rvm_pkg::div_req_t req,
    output rvm_pkg::div_rsp_t rsp
);
    import rvm_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [ELAPSED_W-1:0] rem_reg;
    logic [ELAPSED_W-1:0] rem_next;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DVD_W-1:0]     dvd_next;
    logic [DVD_W-1:0]     quo_reg;
    logic [DVD_W-1:0]     quo_next;
    logic [ELAPSED_W-1:0] dsr_reg;
    logic [ELAPSED_W-1:0] dsr_next;

    logic [ELAPSED_W:0]   shifted;
    logic [ELAPSED_W+1:0] trial;
    logic                 fits;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};
    assign fits    = !trial[ELAPSED_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = '0;
            dvd_next  = req.dividend;
            quo_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops out
            rem_next = fits ? trial[ELAPSED_W-1:0] : shifted[ELAPSED_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/rep_velocity_meter.sv
// ----------------------------------------------------------------------------
// rep_velocity_meter: repetition velocity meter
// Range samples with timestamps in, one velocity result beat out per sample.
// ----------------------------------------------------------------------------
// Input beats (range_cm, time_ms) are taken on in_valid && in_ready; one result
// beat (speed, peak_speed, accel, servo_angle, zero_interval) leaves on
// out_valid && out_ready for every input beat, in order.
// Configuration is written with cfg_we, cfg_index and cfg_data; the user must
// write it only while idle, which the block does not enforce. Each sample runs
// through up to three divisions on one shared restoring divider, one quotient
// bit per cycle: the velocity (first high sample after arming only), the accel
// and the servo angle. Zero elapsed time skips the velocity and accel divisions
// and zero full speed skips the angle division. in_ready is low from acceptance
// until the sequencer is idle again. The result sits in an output register, so
// the next sample may be accepted while it waits; if the receiver still stalls
// when the next result is ready, the sequencer holds until the output register
// frees. Reset restores the default levels, clears the latched start, the held
// and peak speeds, the elapsed time and any pending result.
// ----------------------------------------------------------------------------
module rep_velocity_meter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rvm_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rvm_pkg::RANGE_W-1:0]        range_cm,
    input  logic [rvm_pkg::TIME_W-1:0]         time_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rvm_pkg::SPEED_W-1:0]        speed,
    output logic [rvm_pkg::SPEED_W-1:0]        peak_speed,
    output logic [rvm_pkg::SPEED_W-1:0]        accel,
    output logic [rvm_pkg::SPEED_W-1:0]        servo_angle,
    output logic                               zero_interval
);
    import rvm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_VEL_GO   = 9'b000000010,
        S_VEL_WAIT = 9'b000000100,
        S_HOLD     = 9'b000001000,
        S_ACC_GO   = 9'b000010000,
        S_ACC_WAIT = 9'b000100000,
        S_ANG_GO   = 9'b001000000,
        S_ANG_WAIT = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CFG_W-1:0]     low_reg,   low_next;
    logic [CFG_W-1:0]     high_reg,  high_next;
    logic [CFG_W-1:0]     limit_reg, limit_next;
    logic [CFG_W-1:0]     full_reg,  full_next;

    logic [TIME_W-1:0]    start_time_reg, start_time_next;
    logic [RANGE_W-1:0]   start_pos_reg,  start_pos_next;
    logic                 measured_reg,   measured_next;
    logic [SPEED_W-1:0]   held_reg,       held_next;
    logic [SPEED_W-1:0]   peak_reg,       peak_next;
    logic [ELAPSED_W-1:0] elapsed_reg,    elapsed_next;

    logic                 measure_reg,  measure_next;
    logic [RANGE_W-1:0]   dmag_reg,     dmag_next;
    logic [DVD_W-1:0]     vel_reg,      vel_next;
    logic                 zero_hit_reg, zero_hit_next;
    logic [SPEED_W-1:0]   accel_reg,    accel_next;
    logic [SPEED_W-1:0]   angle_reg,    angle_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]   speed_reg,     speed_next;
    logic [SPEED_W-1:0]   peak_out_reg,  peak_out_next;
    logic [SPEED_W-1:0]   accel_out_reg, accel_out_next;
    logic [SPEED_W-1:0]   angle_out_reg, angle_out_next;
    logic                 zero_out_reg,  zero_out_next;

    logic [RANGE_W-1:0]   range_clamp;
    logic                 at_low;
    logic                 at_high;
    logic [TIME_W-1:0]    st_time_new;
    logic [RANGE_W-1:0]   st_pos_new;
    logic [TIME_W-1:0]    diff;
    logic [ELAPSED_W-1:0] diff_sat;
    logic [RANGE_W-1:0]   dmag;
    logic [SPEED_W-1:0]   held_new;
    logic [PROD_W-1:0]    angle_prod;
    logic                 accept;
    logic                 out_free;

    div_req_t div_req;
    div_rsp_t div_rsp;

    rvm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // latch before measure when the levels overlap
    always_comb
    begin
        range_clamp = (range_cm > MAX_RANGE) ? MAX_RANGE : range_cm;
        at_low      = range_clamp <= low_reg;
        at_high     = range_clamp >= high_reg;
        st_time_new = at_low ? time_ms : start_time_reg;
        st_pos_new  = at_low ? range_clamp : start_pos_reg;
        diff        = time_ms - st_time_new;
        diff_sat    = diff[TIME_W-1] ? ELAPSED_MAX : diff[ELAPSED_W-1:0];
        dmag        = (range_clamp >= st_pos_new) ? (range_clamp - st_pos_new)
                                                  : (st_pos_new - range_clamp);
        held_new    = (vel_reg > DVD_W'(limit_reg)) ? '0 : vel_reg[SPEED_W-1:0];
        angle_prod  = PROD_W'(held_reg) * PROD_W'(FULL_ANGLE);
    end

    always_comb
    begin
        low_next        = low_reg;
        high_next       = high_reg;
        limit_next      = limit_reg;
        full_next       = full_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOW_LEVEL:  low_next   = cfg_data;
                CFG_HIGH_LEVEL: high_next  = cfg_data;
                CFG_ERR_LIMIT:  limit_next = cfg_data;
                CFG_FULL_SPEED: full_next  = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        start_time_next  = start_time_reg;
        start_pos_next   = start_pos_reg;
        measured_next    = measured_reg;
        held_next        = held_reg;
        peak_next        = peak_reg;
        elapsed_next     = elapsed_reg;
        measure_next     = measure_reg;
        dmag_next        = dmag_reg;
        vel_next         = vel_reg;
        zero_hit_next    = zero_hit_reg;
        accel_next       = accel_reg;
        angle_next       = angle_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        speed_next       = speed_reg;
        peak_out_next    = peak_out_reg;
        accel_out_next   = accel_out_reg;
        angle_out_next   = angle_out_reg;
        zero_out_next    = zero_out_reg;
        div_req.start    = 1'b0;
        div_req.iters    = VEL_ITERS;
        div_req.dividend = DVD_W'(dmag_reg) * DVD_W'(SCALE_MS);
        div_req.divisor  = elapsed_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    start_time_next = st_time_new;
                    start_pos_next  = st_pos_new;
                    measured_next   = at_high ? 1'b1 : (at_low ? 1'b0 : measured_reg);
                    measure_next    = at_high && (at_low || !measured_reg);
                    if (at_high)
                    begin
                        elapsed_next = diff_sat;
                    end
                    dmag_next     = dmag;
                    vel_next      = at_low ? '0 : DVD_W'(held_reg);
                    zero_hit_next = 1'b0;
                    state_next    = S_VEL_GO;
                end
            end
            S_VEL_GO:
            begin
                if (measure_reg && (elapsed_reg != '0))
                begin
                    div_req.start = 1'b1;
                    state_next    = S_VEL_WAIT;
                end
                else
                begin
                    if (measure_reg)
                    begin
                        vel_next      = '0;
                        zero_hit_next = 1'b1;
                    end
                    state_next = S_HOLD;
                end
            end
            S_VEL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    vel_next   = div_rsp.quotient;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                held_next  = held_new;
                peak_next  = (held_new > peak_reg) ? held_new : peak_reg;
                state_next = S_ACC_GO;
            end
            S_ACC_GO:
            begin
                if (elapsed_reg == '0)
                begin
                    accel_next    = '0;
                    zero_hit_next = 1'b1;
                    state_next    = S_ANG_GO;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.iters    = ACC_ITERS;
                    div_req.dividend = {held_reg, {(DVD_W-SPEED_W){1'b0}}};
                    state_next       = S_ACC_WAIT;
                end
            end
            S_ACC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    accel_next = div_rsp.quotient[SPEED_W-1:0];
                    state_next = S_ANG_GO;
                end
            end
            S_ANG_GO:
            begin
                if (full_reg == '0)
                begin
                    angle_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.iters    = ANG_ITERS;
                    div_req.dividend = {angle_prod, {(DVD_W-PROD_W){1'b0}}};
                    div_req.divisor  = ELAPSED_W'(full_reg);
                    state_next       = S_ANG_WAIT;
                end
            end
            S_ANG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // saturate at full deflection
                    angle_next = (div_rsp.quotient > DVD_W'(FULL_ANGLE))
                                 ? FULL_ANGLE : div_rsp.quotient[SPEED_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    speed_next     = held_reg;
                    peak_out_next  = peak_reg;
                    accel_out_next = accel_reg;
                    angle_out_next = angle_reg;
                    zero_out_next  = zero_hit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            low_reg        <= LOW_LEVEL_RST;
            high_reg       <= HIGH_LEVEL_RST;
            limit_reg      <= ERR_LIMIT_RST;
            full_reg       <= FULL_SPEED_RST;
            start_time_reg <= '0;
            start_pos_reg  <= '0;
            measured_reg   <= 1'b0;
            held_reg       <= '0;
            peak_reg       <= '0;
            elapsed_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            limit_reg      <= limit_next;
            full_reg       <= full_next;
            start_time_reg <= start_time_next;
            start_pos_reg  <= start_pos_next;
            measured_reg   <= measured_next;
            held_reg       <= held_next;
            peak_reg       <= peak_next;
            elapsed_reg    <= elapsed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        measure_reg   <= measure_next;
        dmag_reg      <= dmag_next;
        vel_reg       <= vel_next;
        zero_hit_reg  <= zero_hit_next;
        accel_reg     <= accel_next;
        angle_reg     <= angle_next;
        speed_reg     <= speed_next;
        peak_out_reg  <= peak_out_next;
        accel_out_reg <= accel_out_next;
        angle_out_reg <= angle_out_next;
        zero_out_reg  <= zero_out_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign speed         = speed_reg;
    assign peak_speed    = peak_out_reg;
    assign accel         = accel_out_reg;
    assign servo_angle   = angle_out_reg;
    assign zero_interval = zero_out_reg;

    // one sample at a time through the sequencer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a sample is in progress");

    a_div_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_peak_covers_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (peak_speed >= speed))
        else $error("peak speed below current speed");

    a_angle_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (servo_angle <= FULL_ANGLE))
        else $error("servo angle beyond full deflection");

endmodule
